// File: hdl/xte_pkg.sv
// Package for the XML text escaper: beat classes, queue entry and escape tables.
package xte_pkg;

  typedef enum logic [3:0] {
    CL_PLAIN = 4'd0,
    CL_LT    = 4'd1,
    CL_GT    = 4'd2,
    CL_QUOT  = 4'd3,
    CL_APOS  = 4'd4,
    CL_AMP   = 4'd5,
    CL_TAB   = 4'd6,
    CL_LF    = 4'd7,
    CL_CR    = 4'd8,
    CL_OCT   = 4'd9
  } xte_class_t;

  typedef struct packed {
    logic [7:0] chr;
    xte_class_t cls;
  } xte_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } xte_qstat_t;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  function automatic xte_class_t xte_classify(input logic [7:0] c);
    xte_class_t r;
    case (c)
      8'h3C:   r = CL_LT;
      8'h3E:   r = CL_GT;
      8'h22:   r = CL_QUOT;
      8'h27:   r = CL_APOS;
      8'h26:   r = CL_AMP;
      8'h09:   r = CL_TAB;
      8'h0A:   r = CL_LF;
      8'h0D:   r = CL_CR;
      8'h00:   r = CL_PLAIN;
      default: r = (c inside {[8'h20:8'h7E]}) ? CL_PLAIN : CL_OCT;
    endcase
    return r;
  endfunction

  // Index of the final byte of the run, i.e. run length minus one.
  function automatic logic [2:0] xte_last_idx(input xte_class_t cls);
    logic [2:0] r;
    case (cls)
      CL_PLAIN: r = 3'd0;
      CL_LT:    r = 3'd3;
      CL_GT:    r = 3'd3;
      CL_QUOT:  r = 3'd5;
      CL_APOS:  r = 3'd5;
      CL_AMP:   r = 3'd4;
      CL_TAB:   r = 3'd3;
      CL_LF:    r = 3'd1;
      CL_CR:    r = 3'd1;
      CL_OCT:   r = 3'd3;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xte_run_byte(input xte_class_t cls, input logic [7:0] c,
                                              input logic [2:0] pos);
    logic [7:0] r;
    r = c;
    case (cls)
      CL_PLAIN: r = c;
      CL_LT:    r = (pos == 3'd0) ? CH_AMP : (pos == 3'd1) ? 8'h6C :
                    (pos == 3'd2) ? 8'h74 : CH_SEMI;
      CL_GT:    r = (pos == 3'd0) ? CH_AMP : (pos == 3'd1) ? 8'h67 :
                    (pos == 3'd2) ? 8'h74 : CH_SEMI;
      CL_QUOT:  r = (pos == 3'd0) ? CH_AMP : (pos == 3'd1) ? 8'h71 :
                    (pos == 3'd2) ? 8'h75 : (pos == 3'd3) ? 8'h6F :
                    (pos == 3'd4) ? 8'h74 : CH_SEMI;
      CL_APOS:  r = (pos == 3'd0) ? CH_AMP : (pos == 3'd1) ? 8'h61 :
                    (pos == 3'd2) ? 8'h70 : (pos == 3'd3) ? 8'h6F :
                    (pos == 3'd4) ? 8'h73 : CH_SEMI;
      CL_AMP:   r = (pos == 3'd0) ? CH_AMP : (pos == 3'd1) ? 8'h61 :
                    (pos == 3'd2) ? 8'h6D : (pos == 3'd3) ? 8'h70 : CH_SEMI;
      CL_TAB:   r = CH_SPACE;
      CL_LF:    r = (pos == 3'd0) ? CH_BSL : 8'h6E;
      CL_CR:    r = (pos == 3'd0) ? CH_BSL : 8'h72;
      CL_OCT:   r = (pos == 3'd0) ? CH_BSL :
                    (pos == 3'd1) ? (CH_ZERO | {6'd0, c[7:6]}) :
                    (pos == 3'd2) ? (CH_ZERO | {5'd0, c[5:3]}) :
                                    (CH_ZERO | {5'd0, c[2:0]});
      default:  r = c;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/xml_text_escaper_core.sv
// Top level of the XML text escaper: front end, queue and back end.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in      | input     | in_valid/in_stall  | in_char[7:0]
//   out     | output    | out_valid/out_stall| out_char[7:0], out_run_last
//
// Each input beat yields a run of one to six output beats (six for &quot; and
// &apos;), one a cycle while out_stall is low; the single output port of the
// back end sets that rate.
// Input beats are taken every cycle while the queue has a free slot, so the
// front keeps accepting while the back end is still expanding earlier bytes.
// Reset is synchronous and active low; it empties the queue and the back end,
// and there is no clearing pass, so the block is ready in the first cycle after.
// A stall on the output freezes the current run; the queue then fills and only
// when it is full does in_stall rise.
module xml_text_escaper_core import xte_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_run_last
);

  // Signals between the three parts: the front classifies and pushes, the
  // queue decouples the two sides and the back end pops one byte per run.
  xte_qstat_t q_stat;
  xte_entry_t push_entry, pop_entry;
  logic       q_push, q_pop;

  xte_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  xte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .stat       (q_stat)
  );

  // The back end holds the byte being expanded and the position within its
  // run; its output is driven from those registers, so a stalled beat holds.
  xte_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_entry      (pop_entry),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

endmodule

// File: hdl/xte_queue.sv
// Short FIFO of classified input bytes between the front and back ends.
module xte_queue import xte_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  xte_entry_t push_entry,
  input  logic       pop,
  output xte_entry_t pop_entry,
  output xte_qstat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  xte_entry_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_FULL);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: hdl/xte_front.sv
// Front end: accepts input beats and classifies each byte for the queue.
module xte_front import xte_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  xte_qstat_t q_stat,
  output logic       q_push,
  output xte_entry_t q_entry
);

  // Stall only while the queue has no free slot.
  assign in_stall      = q_stat.full;
  assign q_push        = in_valid && !q_stat.full;
  assign q_entry.chr   = in_char;
  assign q_entry.cls   = xte_classify(in_char);

endmodule

// File: hdl/xte_back.sv
// Back end: expands a queued byte into its run, one beat a cycle unless stalled.
module xte_back import xte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  xte_qstat_t q_stat,
  input  xte_entry_t q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_run_last
);

  logic       cur_valid_r, cur_valid_nxt;
  xte_entry_t cur_entry_r, cur_entry_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [2:0] last_idx;
  logic       out_fire, load;

  assign last_idx     = xte_last_idx(cur_entry_r.cls);
  assign out_valid    = cur_valid_r;
  assign out_char     = xte_run_byte(cur_entry_r.cls, cur_entry_r.chr, pos_r);
  assign out_run_last = (pos_r == last_idx);
  assign out_fire     = cur_valid_r && !out_stall;
  // Take the next byte when idle or as the final beat of a run leaves.
  assign load         = !cur_valid_r || (out_fire && out_run_last);
  assign q_pop        = load && !q_stat.empty;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_entry_nxt = cur_entry_r;
    pos_nxt       = pos_r;
    if (load) begin
      cur_valid_nxt = !q_stat.empty;
      cur_entry_nxt = q_entry;
      pos_nxt       = '0;
    end else if (out_fire) begin
      pos_nxt = pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_entry_r <= cur_entry_nxt;
  end

  a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (pos_r <= last_idx))
    else $error("emit position beyond end of run");

  a_pos_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_run_last) |=> (cur_valid_r && pos_r == $past(pos_r) + 3'd1))
    else $error("emit position did not advance after a beat");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && out_stall) |=> ($stable(pos_r) && $stable(cur_entry_r) && cur_valid_r))
    else $error("run state changed while output stalled");

endmodule

// File: test/xml_text_escaper_checker.sv
// Checker for the XML text escaper: predicts each escaped run and compares the output beats.
module xml_text_escaper_checker import xte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char,
  input  logic       out_run_last,
  output int         pending_beats,
  output int         mismatch_count
);

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } esc_beat_t;

  esc_beat_t escaped_q[$];

  initial begin
    pending_beats  = 0;
    mismatch_count = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Builds the escaped run of one input byte and queues it, the last beat flagged.
  task automatic queue_escape(input logic [7:0] c);
    string      entity;
    logic [7:0] run[$];
    int         i;
    entity = "";
    case (c)
      8'h00: run.push_back(c);
      8'h3C: entity = "&lt;";
      8'h3E: entity = "&gt;";
      8'h22: entity = "&quot;";
      8'h27: entity = "&apos;";
      8'h26: entity = "&amp;";
      8'h09: entity = "    ";
      8'h0A: entity = "\\n";
      8'h0D: entity = "\\r";
      default: begin
        if (c < 8'h20 || c > 8'h7E) begin
          run.push_back(CH_BSL);
          run.push_back({6'b001100, c[7:6]});
          run.push_back({5'b00110, c[5:3]});
          run.push_back({5'b00110, c[2:0]});
        end else begin
          run.push_back(c);
        end
      end
    endcase
    for (i = 0; i < entity.len(); i++) run.push_back(entity[i]);
    for (i = 0; i < run.size(); i++) begin
      escaped_q.push_back('{chr: run[i], last: (i == run.size() - 1)});
    end
  endtask

  always @(posedge clk) begin : watch
    esc_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) queue_escape(in_char);
      if (out_valid && !out_stall) begin
        if (escaped_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char 0x%02h last %0b",
                                    out_char, out_run_last));
        end else begin
          want = escaped_q.pop_front();
          if (out_char !== want.chr) begin
            report_mismatch($sformatf("out_char 0x%02h, wanted 0x%02h", out_char, want.chr));
          end
          if (out_run_last !== want.last) begin
            report_mismatch($sformatf("out_run_last %0b, wanted %0b on char 0x%02h",
                                      out_run_last, want.last, want.chr));
          end
        end
      end
    end
    pending_beats <= escaped_q.size();
  end

endmodule

// File: test/xml_text_escaper_core_test.sv
// Testbench top for the XML text escaper: stimulus, output stalls, watchdog and verdict.
module xml_text_escaper_core_test;
  import xte_pkg::*;

  // Cycles with no beat accepted on either channel before the run is called hung.
  // The longest correct quiet stretch is a long sender gap or a long receiver stall,
  // and the limit leaves a wide margin over either.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 400;
  localparam int DRAIN_CYCLES   = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_run_last;

  int pending_beats;
  int mismatch_count;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  // Directed bytes: both ends of the range, every escape class, the edges of the
  // printable band, delete and the top half, backslash, and alternating bit patterns.
  logic [7:0] directed_bytes[] = '{
    8'h00, 8'hFF, 8'h7F, 8'h80, 8'h20, 8'h7E, 8'h3C, 8'h3E, 8'h22, 8'h27,
    8'h26, 8'h09, 8'h0A, 8'h0D, 8'h5C, 8'h01, 8'h1F, 8'h55, 8'hAA, 8'h41,
    8'h22, 8'h27, 8'h00, 8'hC3
  };

  // Escaped bytes, plus NUL and backslash, which pass through unchanged.
  logic [7:0] special_bytes[] = '{
    8'h3C, 8'h3E, 8'h22, 8'h27, 8'h26, 8'h09, 8'h0A, 8'h0D, 8'h00, 8'h7F, 8'h5C
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  xml_text_escaper_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char      (in_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

  xml_text_escaper_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char        (in_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_run_last   (out_run_last),
    .pending_beats  (pending_beats),
    .mismatch_count (mismatch_count)
  );

  // Idle length: mostly none or short, now and then a long one. While no_idle is
  // set the sender runs back to back so the queue fills and in_stall is exercised.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Text-like mix: printable bytes, the escaped characters, and anything at all,
  // so that the octal path sees the full top half and the control range.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(32, 126));
    if (r < 70) return special_bytes[$urandom_range(0, special_bytes.size() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one beat on the input channel after an optional idle gap and holds it
  // until accepted. With no gap, valid stays high from the previous beat, so it is
  // never lowered and raised in the same step.
  task automatic send_byte(input logic [7:0] b, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
  endtask

  // Receiver stalls: runs of readiness, mostly with short stalls between them, a few
  // long ones, and every so often a long stretch with no stall at all.
  initial begin : stall_driver
    int run_len;
    int stall_len;
    int r;
    forever begin
      r = $urandom_range(0, 99);
      run_len = (r < 10) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      repeat (run_len) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 50) stall_len = 0;
      else if (r < 88) stall_len = $urandom_range(1, 3);
      else if (r < 96) stall_len = $urandom_range(4, 12);
      else stall_len = $urandom_range(20, 60);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Any accepted beat on either side restarts the count; a block that stops moving
  // with work outstanding, or that never delivers the last of a run, ends here.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < directed_bytes.size(); i++) send_byte(directed_bytes[i], pick_gap());
    for (i = 0; i < RANDOM_BYTES; i++) send_byte(pick_byte(), pick_gap());
    in_valid <= 1'b0;

    // Drain: one edge first so the count includes the run of the last accepted
    // byte, then every predicted beat must arrive, and a short quiet spell catches
    // any stray beats the block might still emit.
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
